/* sv/dss_pkg.sv */
`timescale 1ns / 1ps

package dss_pkg;

    localparam int VAL_W        = 8;
    localparam int POS_W        = 4;
    localparam int STORE_DEPTH  = 16;
    localparam int SET_SIZE_DEF = 16;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             set_end;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] sorted_value;
        logic [POS_W-1:0] position;
        logic             run_last;
        logic             overflowed;
    } t_res;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

/* sv/dss_cell.sv */
`timescale 1ns / 1ps

module dss_cell (
    input  logic                     i_clk,
    input  dss_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_occupied,
    input  logic [dss_pkg::VAL_W-1:0] i_in_val,
    input  logic                     i_prev_keep,
    input  logic [dss_pkg::VAL_W-1:0] i_prev_val,
    input  logic [dss_pkg::VAL_W-1:0] i_next_val,
    output logic                     o_keep,
    output logic [dss_pkg::VAL_W-1:0] o_val
);
    import dss_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;

    // A cell keeps its value when it holds one at least as large as the new value.
    assign o_keep = i_occupied && (i_in_val <= r_val);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (o_keep) begin
                n_val = r_val;
            end else if (i_prev_keep) begin
                n_val = i_in_val;
            end else begin
                n_val = i_prev_val;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* sv/descending_set_sorter_top.sv */
// A request without the end mark is stored (dropped when the store is full) and busy stays low.
// A request with the end mark raises busy while its n stored values (1 to CAP) are emitted;
// the first result is registered through r_emit and then o_valid, then one result per cycle.
// One request per cycle is taken while loading; none is taken while busy is high during emission.
// Synchronous active-low reset clears the fill count, the drop flag, busy and the strobe.
// Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module descending_set_sorter_top #(
    parameter int SET_SIZE = dss_pkg::SET_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  dss_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output dss_pkg::t_res o_res
);
    import dss_pkg::*;

    localparam int CAP   = (SET_SIZE < STORE_DEPTH) ? SET_SIZE : STORE_DEPTH;
    localparam int CNT_W = $clog2(CAP + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_drop;
    logic             r_emit;
    logic [POS_W-1:0] r_pos;
    logic             accept;
    logic             full;
    t_cell_ctl        cell_ctl;
    logic             w_keep [CAP];
    logic [VAL_W-1:0] w_val  [CAP];

    assign accept = start && !busy;
    assign full   = (r_cnt == CNT_W'(CAP));
    assign busy   = r_emit;
    assign n_cnt  = full ? r_cnt : r_cnt + 1'b1;

    assign cell_ctl.insert = accept && !full;
    assign cell_ctl.shift  = r_emit;

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic             prev_keep;
        logic [VAL_W-1:0] prev_val;
        logic [VAL_W-1:0] next_val;

        if (i == 0) begin : g_first
            assign prev_keep = 1'b1;
            assign prev_val  = i_req.value;
        end else begin : g_mid
            assign prev_keep = w_keep[i-1];
            assign prev_val  = w_val[i-1];
        end

        if (i == CAP - 1) begin : g_last
            assign next_val = w_val[i];
        end else begin : g_inner
            assign next_val = w_val[i+1];
        end

        dss_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_occupied  (r_cnt > CNT_W'(i)),
            .i_in_val    (i_req.value),
            .i_prev_keep (prev_keep),
            .i_prev_val  (prev_val),
            .i_next_val  (next_val),
            .o_keep      (w_keep[i]),
            .o_val       (w_val[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_emit  <= 1'b0;
            r_pos   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_emit;
            if (r_emit) begin
                o_res.sorted_value  <= w_val[0];
                o_res.position      <= r_pos;
                o_res.run_last      <= (r_cnt == CNT_W'(1));
                o_res.overflowed    <= r_drop;
                r_pos               <= r_pos + 1'b1;
                r_cnt               <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_emit <= 1'b0;
                    r_drop <= 1'b0;
                end
            end else if (accept) begin
                r_cnt  <= n_cnt;
                r_drop <= r_drop || full;
                if (i_req.set_end) begin
                    r_emit <= 1'b1;
                    r_pos  <= '0;
                end
            end
        end
    end

endmodule

/* sv/dss_checker.sv */
`timescale 1ns / 1ps

module dss_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input dss_pkg::t_req i_req,
    input logic          busy,
    input logic          o_valid,
    input dss_pkg::t_res o_res
);
    import dss_pkg::*;

    a_end_raises_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.set_end |=> busy)
        else $error("end of set did not start emission");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.run_last |=> o_valid)
        else $error("gap inside a sorted run");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.run_last |=> !o_valid)
        else $error("result after the last of a run");

    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.run_last |=>
            o_res.position == $past(o_res.position) + 4'd1)
        else $error("position did not advance by one");

    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.run_last |=> o_res.sorted_value <= $past(o_res.sorted_value))
        else $error("sorted run is not descending");

endmodule

bind descending_set_sorter_top dss_checker u_dss_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);
